// File: design/ska_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ska_pkg
// Shared types and constants of the sorted key accumulator table.
// ----------------------------------------------------------------------------
package ska_pkg;

  localparam int unsigned DefTableDepth = 256;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INVALID_REF = 2'd1,
    ST_FULL        = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KT_COST     = 2'd0,
    KT_LANDING  = 2'd1,
    KT_TACTICAL = 2'd2,
    KT_STRATEGY = 2'd3
  } key_type_e;

  typedef struct packed {
    logic [1:0]  key_type;
    logic [31:0] key_primary;
    logic [31:0] key_secondary;
    logic [7:0]  key_stance;
    logic [63:0] obs_value;
    logic        from_human;
    logic        reference_valid;
  } obs_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  entry_index;
    logic        was_new;
    logic [63:0] value_total;
    logic [63:0] human_count;
    logic [63:0] bot_count;
    logic [8:0]  entry_count;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_CHK_RD,
    S_CHK_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_UPD,
    S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch the word, clear search
    logic rd_mid;      // read entry at first+half
    logic step_cmp;    // apply compare result to search window
    logic rd_first;    // read entry at first
    logic shift_init;  // pointer = occupied
    logic shift_rd;    // read entry pointer-1
    logic shift_wr;    // write to pointer, decrement
    logic upd;         // write updated entry, form result
    logic res_inval;
    logic res_full;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic invalid;
    logic cnt_zero;
    logic found;
    logic full;
    logic shift_done;
  } sts_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage
`default_nettype wire

// File: design/ska_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ska_stream_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface ska_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/ska_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ska_ctrl
// Sequencer: search, check, shift, update, deliver.
// ----------------------------------------------------------------------------
module ska_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire ska_pkg::sts_t sts_i,
  output ska_pkg::ctl_t      ctl_o
);
  import ska_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctl_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (sts_i.invalid) begin
          ctl_o.res_inval = 1'b1;
          state_d         = S_OUT;
        end else if (sts_i.cnt_zero) begin
          ctl_o.rd_first = 1'b1;
          state_d        = S_CHK_RD;
        end else begin
          ctl_o.rd_mid = 1'b1;
          state_d      = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        ctl_o.step_cmp = 1'b1;
        state_d        = S_SRCH_RD;
      end
      S_CHK_RD: begin
        state_d = S_CHK_CMP;
      end
      S_CHK_CMP: begin
        if (sts_i.found) begin
          state_d = S_UPD;
        end else if (sts_i.full) begin
          ctl_o.res_full = 1'b1;
          state_d        = S_OUT;
        end else begin
          ctl_o.shift_init = 1'b1;
          state_d          = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts_i.shift_done) begin
          state_d = S_UPD;
        end else begin
          ctl_o.shift_rd = 1'b1;
          state_d        = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        ctl_o.shift_wr = 1'b1;
        state_d        = S_SHIFT_RD;
      end
      S_UPD: begin
        ctl_o.upd = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: design/ska_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ska_dpath
// Entry memory, search window, compare, shift pointer and saturating update.
// ----------------------------------------------------------------------------
module ska_dpath #(
  parameter int unsigned TableDepth = ska_pkg::DefTableDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ska_pkg::obs_t obs_i,
  input  wire ska_pkg::ctl_t ctl_i,
  output ska_pkg::sts_t      sts_o,
  output ska_pkg::res_t      res_o
);
  import ska_pkg::*;

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned CW = AW + 1;

  typedef struct packed {
    logic [1:0]  ktype;
    logic [31:0] pri;
    logic [31:0] sec;
    logic [7:0]  stance;
    logic [63:0] total;
    logic [63:0] hum;
    logic [63:0] bot;
  } entry_t;

  entry_t       mem [TableDepth];
  entry_t       rd_q;
  obs_t         obs_q;
  logic [CW-1:0] occ_q, first_q, count_q, ptr_q;
  res_t         res_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic         wr_en;
  entry_t       wr_data;
  logic [CW-1:0] half, mid;
  logic [73:0]  key_probe, key_rd;
  entry_t       upd_e;
  logic         found;

  always_comb begin
    key_probe = {obs_q.key_type, obs_q.key_primary,
                 (obs_q.key_type == KT_LANDING) ? 32'd0 : obs_q.key_secondary,
                 obs_q.key_type[1] ? 8'd0 : obs_q.key_stance};
    key_rd    = {rd_q.ktype, rd_q.pri, rd_q.sec, rd_q.stance};
    half      = count_q >> 1;
    mid       = first_q + half;
    found     = (first_q < occ_q) && (key_rd == key_probe);
  end

  always_comb begin
    rd_addr = first_q[AW-1:0];
    if (ctl_i.rd_mid) begin
      rd_addr = mid[AW-1:0];
    end else if (ctl_i.shift_rd) begin
      rd_addr = AW'(ptr_q - 1'b1);
    end else if (ctl_i.rd_first) begin
      rd_addr = first_q[AW-1:0];
    end
  end

  always_comb begin
    upd_e = found ? rd_q : '0;
    upd_e.ktype  = key_probe[73:72];
    upd_e.pri    = key_probe[71:40];
    upd_e.sec    = key_probe[39:8];
    upd_e.stance = key_probe[7:0];
    upd_e.total  = sat_add(upd_e.total, obs_q.obs_value);
    if (obs_q.from_human) begin
      upd_e.hum = sat_add(upd_e.hum, 64'd1);
    end else begin
      upd_e.bot = sat_add(upd_e.bot, 64'd1);
    end
    wr_en   = ctl_i.shift_wr || ctl_i.upd;
    wr_addr = ctl_i.upd ? first_q[AW-1:0] : ptr_q[AW-1:0];
    wr_data = ctl_i.upd ? upd_e : rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      first_q <= '0;
      count_q <= '0;
      ptr_q   <= '0;
    end else begin
      if (ctl_i.load) begin
        first_q <= '0;
        count_q <= occ_q;
      end
      if (ctl_i.step_cmp) begin
        if (key_rd < key_probe) begin
          first_q <= mid + 1'b1;
          count_q <= count_q - half - 1'b1;
        end else begin
          count_q <= half;
        end
      end
      if (ctl_i.shift_init) begin
        ptr_q <= occ_q;
      end
      if (ctl_i.shift_wr) begin
        ptr_q <= ptr_q - 1'b1;
      end
      if (ctl_i.upd && !found) begin
        occ_q <= occ_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      obs_q <= obs_i;
    end
    if (ctl_i.res_inval || ctl_i.res_full) begin
      res_q <= {(ctl_i.res_inval ? ST_INVALID_REF : ST_FULL), 8'd0, 1'b0,
                64'd0, 64'd0, 64'd0, 9'(occ_q)};
    end
    if (ctl_i.upd) begin
      res_q.status      <= ST_OK;
      res_q.entry_index <= 8'(first_q);
      res_q.was_new     <= !found;
      res_q.value_total <= upd_e.total;
      res_q.human_count <= upd_e.hum;
      res_q.bot_count   <= upd_e.bot;
      res_q.entry_count <= 9'(found ? occ_q : occ_q + 1'b1);
    end
  end

  assign sts_o.invalid    = !obs_q.reference_valid;
  assign sts_o.cnt_zero   = (count_q == '0);
  assign sts_o.found      = found;
  assign sts_o.full       = (occ_q >= CW'(TableDepth));
  assign sts_o.shift_done = (ptr_q == first_q);
  assign res_o            = res_q;

endmodule
`default_nettype wire

// File: design/sorted_key_accumulator_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_accumulator_table
// Sorted key table with binary search, ordered insert and saturating sums.
// ----------------------------------------------------------------------------
// One word at a time. After a word is taken, the search probes the entry
// memory (one read port, one write port) at most log2(n)+1 times; then come
// the check, for an insert the move of each later entry up by one, the
// update and the output of the result. The block takes the next word once
// the result is taken.
module sorted_key_accumulator_table #(
  parameter int unsigned TABLE_DEPTH = ska_pkg::DefTableDepth
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  ska_stream_if.sink   obs_i,
  ska_stream_if.source res_o
);
  import ska_pkg::*;

  ctl_t ctl;
  sts_t sts;
  res_t res;

  ska_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (obs_i.valid),
    .in_ready_o  (obs_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  ska_dpath #(.TableDepth(TABLE_DEPTH)) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .obs_i  (obs_i.data),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .res_o  (res)
  );

  assign res_o.data = res;

endmodule
`default_nettype wire

// File: tb/sorted_key_accumulator_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_accumulator_table_test
// Drives observations into the sorted key table and checks every result word
// against a behavioral table kept in the bench: lower-bound search, ordered
// insert, saturating sums, invalid reference and table full handling.
// ----------------------------------------------------------------------------
module sorted_key_accumulator_table_test;
  import ska_pkg::*;

  localparam int Depth = 256;
  localparam int WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  ska_stream_if #(.T(obs_t)) obs_if ();
  ska_stream_if #(.T(res_t)) res_if ();

  sorted_key_accumulator_table #(.TABLE_DEPTH(Depth)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .obs_i (obs_if.sink),
    .res_o (res_if.source)
  );

  // bench copy of the table
  logic [9:0]  tbl_ts[Depth];
  logic [31:0] tbl_pri[Depth];
  logic [31:0] tbl_sec[Depth];
  logic [63:0] tbl_val[Depth];
  logic [63:0] tbl_hum[Depth];
  logic [63:0] tbl_bot[Depth];
  int unsigned tbl_used = 0;

  obs_t pending_words[$];
  res_t expected_results[$];
  int errors = 0;
  int n_sent = 0, n_recv = 0, n_full = 0, n_inval = 0, n_new = 0;
  bit quiet_src = 1'b0, quiet_snk = 1'b0, hold_src = 1'b0;
  int idle_cycles = 0;

  function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic res_t accumulate(obs_t o);
    res_t r;
    logic [73:0] key, ek;
    int unsigned lo, cnt, half, mid;
    logic [31:0] sec;
    logic [7:0] stn;
    bit hit;
    r = '0;
    sec = (o.key_type == KT_LANDING) ? 32'd0 : o.key_secondary;
    stn = (o.key_type == KT_TACTICAL || o.key_type == KT_STRATEGY) ? 8'd0 : o.key_stance;
    key = {o.key_type, o.key_primary, sec, stn};
    r.entry_count = tbl_used[8:0];
    if (!o.reference_valid) begin
      r.status = ST_INVALID_REF;
      return r;
    end
    lo = 0;
    cnt = tbl_used;
    while (cnt != 0) begin
      half = cnt / 2;
      mid = lo + half;
      ek = {tbl_ts[mid][9:8], tbl_pri[mid], tbl_sec[mid], tbl_ts[mid][7:0]};
      if (ek < key) begin
        lo = mid + 1;
        cnt -= half + 1;
      end else begin
        cnt = half;
      end
    end
    hit = 1'b0;
    if (lo < tbl_used)
      hit = ({tbl_ts[lo][9:8], tbl_pri[lo], tbl_sec[lo], tbl_ts[lo][7:0]} == key);
    if (!hit) begin
      if (tbl_used >= Depth) begin
        r.status = ST_FULL;
        return r;
      end
      for (int i = int'(tbl_used); i > int'(lo); i--) begin
        tbl_ts[i] = tbl_ts[i-1]; tbl_pri[i] = tbl_pri[i-1]; tbl_sec[i] = tbl_sec[i-1];
        tbl_val[i] = tbl_val[i-1]; tbl_hum[i] = tbl_hum[i-1]; tbl_bot[i] = tbl_bot[i-1];
      end
      tbl_ts[lo] = {o.key_type, stn}; tbl_pri[lo] = o.key_primary; tbl_sec[lo] = sec;
      tbl_val[lo] = '0; tbl_hum[lo] = '0; tbl_bot[lo] = '0;
      tbl_used++;
      r.was_new = 1'b1;
    end
    tbl_val[lo] = add_clamped(tbl_val[lo], o.obs_value);
    if (o.from_human) tbl_hum[lo] = add_clamped(tbl_hum[lo], 64'd1);
    else tbl_bot[lo] = add_clamped(tbl_bot[lo], 64'd1);
    r.status = ST_OK;
    r.entry_index = lo[7:0];
    r.value_total = tbl_val[lo];
    r.human_count = tbl_hum[lo];
    r.bot_count = tbl_bot[lo];
    r.entry_count = tbl_used[8:0];
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs_if.valid <= 1'b0;
      obs_if.data <= '0;
    end else begin
      if (obs_if.valid && obs_if.ready) begin
        expected_results.push_back(accumulate(obs_if.data));
        n_sent++;
      end
      if (!obs_if.valid || obs_if.ready) begin
        if (pending_words.size() != 0 && !hold_src
            && (quiet_src || $urandom_range(99) >= 14)) begin
          obs_if.valid <= 1'b1;
          obs_if.data <= pending_words.pop_front();
        end else begin
          obs_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        n_recv++;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          res_t e, a;
          e = expected_results.pop_front();
          a = res_if.data;
          if (a.status != e.status) begin
            $error("status exp %0d got %0d", e.status, a.status); errors++;
          end
          if (a.entry_index != e.entry_index) begin
            $error("entry_index exp %0d got %0d", e.entry_index, a.entry_index); errors++;
          end
          if (a.was_new != e.was_new) begin
            $error("was_new exp %0d got %0d", e.was_new, a.was_new); errors++;
          end
          if (a.value_total != e.value_total) begin
            $error("value_total exp %h got %h", e.value_total, a.value_total); errors++;
          end
          if (a.human_count != e.human_count) begin
            $error("human_count exp %h got %h", e.human_count, a.human_count); errors++;
          end
          if (a.bot_count != e.bot_count) begin
            $error("bot_count exp %h got %h", e.bot_count, a.bot_count); errors++;
          end
          if (a.entry_count != e.entry_count) begin
            $error("entry_count exp %0d got %0d", e.entry_count, a.entry_count); errors++;
          end
          if (e.status == ST_FULL) n_full++;
          if (e.status == ST_INVALID_REF) n_inval++;
          if (e.was_new) n_new++;
        end
      end
      res_if.ready <= quiet_snk || ($urandom_range(99) >= 14);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((obs_if.valid && obs_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic obs_t make_word(logic [1:0] kt, logic [31:0] p, logic [31:0] s,
                                     logic [7:0] st, logic [63:0] v, bit h, bit rv);
    obs_t o;
    o.key_type = kt; o.key_primary = p; o.key_secondary = s; o.key_stance = st;
    o.obs_value = v; o.from_human = h; o.reference_valid = rv;
    return o;
  endfunction

  // small key space so hits are common; occasional wide fields
  function automatic obs_t rand_word(int keyspace);
    obs_t o;
    o.key_type = 2'($urandom_range(3));
    o.key_primary = ($urandom_range(9) == 0) ? $urandom : $urandom_range(keyspace);
    o.key_secondary = ($urandom_range(9) == 0) ? $urandom : $urandom_range(3);
    o.key_stance = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(2));
    o.obs_value = ($urandom_range(19) == 0) ? {$urandom, $urandom}
                                            : 64'($urandom_range(65535));
    o.from_human = 1'($urandom_range(1));
    o.reference_valid = ($urandom_range(15) != 0);
    return o;
  endfunction

  task automatic drain();
    while (pending_words.size() != 0 || obs_if.valid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    obs_if.valid = 1'b0;
    obs_if.data = '0;
    res_if.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, canonical keys, saturation, invalid reference
    pending_words.push_back(make_word(KT_COST, '1, '1, 8'hFF, '1, 1'b1, 1'b1));
    pending_words.push_back(make_word(KT_COST, '1, '1, 8'hFF, 64'd5, 1'b0, 1'b1));
    pending_words.push_back(make_word(KT_COST, 32'd0, 32'd0, 8'd0, 64'd0, 1'b0, 1'b1));
    pending_words.push_back(make_word(KT_LANDING, 32'd7, 32'hDEAD, 8'd3, 64'd10, 1'b1, 1'b1));
    pending_words.push_back(make_word(KT_LANDING, 32'd7, 32'h1234, 8'd3, 64'd20, 1'b0, 1'b1));
    pending_words.push_back(make_word(KT_TACTICAL, 32'd7, 32'd9, 8'hAA, 64'd1, 1'b1, 1'b1));
    pending_words.push_back(make_word(KT_TACTICAL, 32'd7, 32'd9, 8'h55, 64'd1, 1'b0, 1'b1));
    pending_words.push_back(make_word(KT_STRATEGY, '1, '1, 8'hFF, '1, 1'b0, 1'b1));
    pending_words.push_back(make_word(KT_STRATEGY, 32'd0, 32'd0, 8'd0, 64'd3, 1'b1, 1'b1));
    pending_words.push_back(make_word(KT_COST, 32'd5, 32'd5, 8'd5, 64'd9, 1'b1, 1'b0));
    pending_words.push_back(make_word(KT_STRATEGY, '1, '1, 8'hFF, '1, 1'b1, 1'b0));
    pending_words.push_back(make_word(KT_COST, 32'd0, 32'd0, 8'd1,
                                      64'h8000_0000_0000_0000, 1'b1, 1'b1));
    pending_words.push_back(make_word(KT_COST, 32'd0, 32'd0, 8'd1,
                                      64'h8000_0000_0000_0000, 1'b1, 1'b1));
    drain();

    // random, small key space, one long stretch without idling
    for (int i = 0; i < 300; i++) begin
      pending_words.push_back(rand_word(7));
      if (i == 150) begin
        quiet_src = 1'b1;
        quiet_snk = 1'b1;
      end
      if (i == 250) begin
        quiet_src = 1'b0;
        quiet_snk = 1'b0;
      end
      while (pending_words.size() > 4) @(posedge clk_i);
    end
    // sender holds off until every result is back
    hold_src = 1'b1;
    while (obs_if.valid || expected_results.size() != 0) @(posedge clk_i);
    hold_src = 1'b0;

    // fill to full: unique keys, then hits and misses on a full table
    for (int i = 0; i < 300; i++) begin
      pending_words.push_back(make_word(KT_COST, 32'd1000 + i, 32'd0, 8'd0,
                                        64'($urandom_range(255)),
                                        1'($urandom_range(1)), 1'b1));
      while (pending_words.size() > 4) @(posedge clk_i);
    end
    for (int i = 0; i < 250; i++) begin
      pending_words.push_back(rand_word(1500));
      while (pending_words.size() > 4) @(posedge clk_i);
    end
    drain();
    repeat (600) @(posedge clk_i);

    $display("words sent %0d, results %0d: %0d inserts, %0d invalid, %0d table full",
             n_sent, n_recv, n_new, n_inval, n_full);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: sorted_key_accumulator_table.f
design/ska_pkg.sv
design/ska_stream_if.sv
design/ska_ctrl.sv
design/ska_dpath.sv
design/sorted_key_accumulator_table.sv
tb/sorted_key_accumulator_table_test.sv
